// ----- design/tdas_pkg.sv -----
package tdas_pkg;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_ELEM  = 2'd0,
    FUNC_PAIR  = 2'd1,
    FUNC_TRACE = 2'd2,
    FUNC_PIXEL = 2'd3
  } func_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_COUNT  = 2'd0;
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd1;
  localparam logic [1:0] REG_START_OFFSET = 2'd2;
  localparam logic [1:0] REG_SAMPLES_PER  = 2'd3;

  // Table sizes; the address packing relies on powers of two.
  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned MAX_FRAMES   = 256;
  localparam int unsigned MAX_SAMPLES  = 1024;

  localparam int unsigned CfgWidth  = 32;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned PixelW    = 48;
  localparam int unsigned RootW     = 34;
  localparam int unsigned SqW       = 68;
  localparam int unsigned InDataW   = 160;
  localparam int unsigned OutDataW  = 48;

endpackage

// ----- design/tdas_ram.sv -----
module tdas_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/tfm_delay_and_sum_3d_core.sv -----
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     tdata: load or pixel item
// m_axis    out        m_axis_tvalid/tready     tdata: pixel_value
// cfg       in         cfg_we_i                 cfg_idx_i, cfg_data_i
// Load words are accepted back to back while no pixel is in work. For each frame
// a pixel runs two 34-step square roots in one restoring-root unit, and squares
// and scaling share one 32x32 multiplier; the finished sum then moves into the
// output register.
// Reset sets control and configuration registers to their defaults; the stores are not cleared.
// The input is not ready while a pixel is in work, or while a finished sum waits
// because the output register still holds a result that is not yet taken.
module tfm_delay_and_sum_3d_core
  import tdas_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // From bit 0: func[1:0], element_index[7:2], frame_index[15:8],
  // sample_index[25:16], tx_element[31:26], rx_element[37:32], pos_x[69:38],
  // pos_y[101:70], pos_z[133:102], sample_value[149:134], zero fill.
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // From bit 0: pixel_value[47:0].
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  localparam int unsigned EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned SW = $clog2(MAX_SAMPLES);
  localparam int unsigned TW = $clog2(MAX_FRAMES * MAX_SAMPLES);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_PAIR  = 11'b00000000010,
    ST_ELEM  = 11'b00000000100,
    ST_DIFF  = 11'b00000001000,
    ST_SQ    = 11'b00000010000,
    ST_ROOT  = 11'b00000100000,
    ST_SCALE = 11'b00001000000,
    ST_RD0   = 11'b00010000000,
    ST_RD1   = 11'b00100000000,
    ST_ACC   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_e;

  // Input fields.
  logic [1:0]         in_func;
  logic [7:0]         in_elem;
  logic [7:0]         in_frame;
  logic [9:0]         in_sample;
  logic [5:0]         in_tx, in_rx;
  logic [CoordW-1:0]  in_x, in_y, in_z;
  logic [SampleW-1:0] in_val;
  assign in_func   = s_axis_tdata[1:0];
  assign in_elem   = {2'b00, s_axis_tdata[7:2]};
  assign in_frame  = s_axis_tdata[15:8];
  assign in_sample = s_axis_tdata[25:16];
  assign in_tx     = s_axis_tdata[31:26];
  assign in_rx     = s_axis_tdata[37:32];
  assign in_x      = s_axis_tdata[69:38];
  assign in_y      = s_axis_tdata[101:70];
  assign in_z      = s_axis_tdata[133:102];
  assign in_val    = s_axis_tdata[149:134];

  // Configuration registers.
  logic [8:0]  frame_count_q;
  logic [10:0] sample_count_q;
  logic [31:0] start_offset_q;
  logic [31:0] spl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q  <= 9'd1;
      sample_count_q <= 11'd1024;
      start_offset_q <= '0;
      spl_q          <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_COUNT:  frame_count_q  <= cfg_data_i[8:0];
        REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[10:0];
        REG_START_OFFSET: start_offset_q <= cfg_data_i;
        REG_SAMPLES_PER:  spl_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Output register: a finished sum moves in when it is free or being taken.
  logic              out_valid_q;
  logic [PixelW-1:0] out_q;
  logic              out_load;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // Pixel work registers.
  logic [CoordW-1:0]  px_q, py_q, pz_q;
  logic [FW:0]        frame_q;
  logic               side_q;       // 0: transmitter, 1: receiver
  logic [EW-1:0]      rx_q;
  logic [1:0]         axis_q;       // squaring axis
  logic [CoordW-1:0]  diff_q [3];
  logic [SqW:0]       sum_q;        // sum of squares, 69 bits
  logic [RootW-1:0]   root_q;
  logic [5:0]         bit_q;
  logic [RootW:0]     dist_q;       // two distances, 35 bits
  logic [1:0]         scl_q;
  logic [67:0]        prod_q;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic signed [PixelW-1:0] acc_q;
  logic [SW-1:0]      i0_q;
  logic [15:0]        w_q;
  logic signed [SampleW-1:0] s0_q;
  logic               run_q;

  // Effective counts.
  logic [FW:0]  nf;
  logic [SW:0]  ns;
  assign nf = (frame_count_q > 9'(MAX_FRAMES)) ? (FW+1)'(MAX_FRAMES) : (FW+1)'(frame_count_q);
  assign ns = (sample_count_q > 11'(MAX_SAMPLES)) ? (SW+1)'(MAX_SAMPLES)
                                                  : (SW+1)'(sample_count_q);

  // Stores.
  logic             el_we;
  logic [EW-1:0]    el_waddr, el_raddr;
  logic [95:0]      el_rdata;
  logic             pr_we;
  logic [FW-1:0]    pr_waddr, pr_raddr;
  logic [11:0]      pr_rdata;
  logic             tr_we;
  logic [TW-1:0]    tr_waddr, tr_raddr;
  logic [15:0]      tr_rdata;

  assign el_we    = accept && in_func == FUNC_ELEM && in_elem < 8'(MAX_ELEMENTS);
  assign el_waddr = EW'(in_elem);
  assign pr_we    = accept && in_func == FUNC_PAIR && {4'd0, in_frame} < 12'(MAX_FRAMES);
  assign pr_waddr = FW'(in_frame);
  assign tr_we    = accept && in_func == FUNC_TRACE && {4'd0, in_frame} < 12'(MAX_FRAMES)
                    && {3'd0, in_sample} < 13'(MAX_SAMPLES);
  assign tr_waddr = TW'({FW'(in_frame), SW'(in_sample)});
  assign pr_raddr = FW'(frame_q);

  tdas_ram #(.Width(96), .Depth(MAX_ELEMENTS)) u_elem (
    .clk_i, .we_i(el_we), .waddr_i(el_waddr), .wdata_i({in_z, in_y, in_x}),
    .raddr_i(el_raddr), .rdata_o(el_rdata));
  tdas_ram #(.Width(12), .Depth(MAX_FRAMES)) u_pair (
    .clk_i, .we_i(pr_we), .waddr_i(pr_waddr), .wdata_i({in_rx, in_tx}),
    .raddr_i(pr_raddr), .rdata_o(pr_rdata));
  tdas_ram #(.Width(16), .Depth(MAX_FRAMES * MAX_SAMPLES)) u_trace (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(in_val),
    .raddr_i(tr_raddr), .rdata_o(tr_rdata));

  // Position and bounds.
  logic signed [64:0] q;
  logic [47:0] i0w;
  logic        in_range;
  assign q = $signed({1'b0, prod_q[63:0]}) - 65'(signed'(start_offset_q));
  assign i0w = q[63:16];
  assign in_range = !q[64] && (ns >= (SW+1)'(2)) && (i0w < 48'(ns - (SW+1)'(1)));

  // Element read: transmitter from the pair store, receiver from its copy.
  assign el_raddr = side_q ? rx_q : EW'(pr_rdata[5:0]);
  // Trace read: the lower sample while the position is checked, then the upper one.
  logic [SW-1:0] tr_rd_sample;
  assign tr_rd_sample = (state_q == ST_RD1) ? SW'(i0_q + SW'(1)) : SW'(i0w);
  assign tr_raddr = TW'({FW'(frame_q), tr_rd_sample});

  // Absolute differences.
  function automatic logic [CoordW-1:0] absd(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? CoordW'(-d) : CoordW'(d);
  endfunction

  // Shared multiplier: squares during ST_SQ, scaling during ST_SCALE.
  logic [CoordW-1:0] sqv;
  assign sqv = diff_q[axis_q];
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    if (state_q == ST_SQ) begin
      mul_a = sqv;
      mul_b = sqv;
    end else if (state_q == ST_SCALE) begin
      mul_a = (scl_q == 2'd0) ? dist_q[31:0] : {29'd0, dist_q[34:32]};
      mul_b = spl_q;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Root trial: (r | bit)^2 = r^2 + 2 r bit + bit^2, kept incrementally.
  logic [SqW-1:0] rsq_q;
  logic [RootW-1:0] cand;
  logic [SqW-1:0] cand_sq;
  assign cand    = root_q | (RootW'(1) << bit_q);
  assign cand_sq = rsq_q + (SqW'(root_q) << (bit_q + 6'd1)) + (SqW'(1) << (2 * bit_q));

  // Contribution and saturation.
  logic signed [17:0] w0, w1;
  logic signed [35:0] contrib;
  logic signed [PixelW:0] acc_sum;
  logic signed [PixelW-1:0] acc_sat;
  localparam logic signed [PixelW:0] Lim = (PixelW+1)'((64'd1 << (PixelW - 1)) - 64'd1);
  localparam logic signed [PixelW:0] LimN = ~Lim;
  assign w0 = 18'sd65536 - $signed({2'b00, w_q});
  assign w1 = $signed({2'b00, w_q});
  assign contrib = w0 * s0_q + w1 * $signed(tr_rdata);
  assign acc_sum = $signed({acc_q[PixelW-1], acc_q}) + (PixelW+1)'(contrib);
  always_comb begin
    if (acc_sum > Lim) acc_sat = Lim[PixelW-1:0];
    else if (acc_sum < LimN) acc_sat = LimN[PixelW-1:0];
    else acc_sat = acc_sum[PixelW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && in_func == FUNC_PIXEL) begin
                  state_d = (nf == '0 || ns < (SW+1)'(2)) ? ST_OUT : ST_PAIR;
                end
      ST_PAIR:  state_d = ST_ELEM;
      ST_ELEM:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SQ;
      ST_SQ:    if (axis_q == 2'd2) state_d = ST_ROOT;
      ST_ROOT:  if (bit_q == 6'd0) state_d = side_q ? ST_SCALE : ST_ELEM;
      ST_SCALE: if (scl_q == 2'd1) state_d = ST_RD0;
      ST_RD0:   state_d = in_range ? ST_RD1 : ((frame_q + 1'b1 == nf) ? ST_OUT : ST_PAIR);
      ST_RD1:   state_d = ST_ACC;
      ST_ACC:   state_d = (frame_q + 1'b1 == nf) ? ST_OUT : ST_PAIR;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= (state_d != ST_IDLE) && (state_d != ST_OUT);
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= acc_q;
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        px_q <= in_x; py_q <= in_y; pz_q <= in_z;
        frame_q <= '0; acc_q <= '0; side_q <= 1'b0; dist_q <= '0;
      end
      ST_PAIR: begin
        side_q <= 1'b0;
        dist_q <= '0;
      end
      ST_ELEM: rx_q <= EW'(pr_rdata[11:6]);
      ST_DIFF: begin
        diff_q[0] <= absd(px_q, el_rdata[31:0]);
        diff_q[1] <= absd(py_q, el_rdata[63:32]);
        diff_q[2] <= absd(pz_q, el_rdata[95:64]);
        axis_q <= 2'd0;
        sum_q  <= '0;
      end
      ST_SQ: begin
        // Differences fit in 32 bits, so each square is one multiplier pass.
        sum_q  <= sum_q + (SqW+1)'(mul_p);
        axis_q <= axis_q + 2'd1;
        root_q <= '0; rsq_q <= '0; bit_q <= 6'd33;
      end
      ST_ROOT: begin
        if ((SqW+1)'(cand_sq) <= sum_q) begin
          root_q <= cand;
          rsq_q  <= cand_sq;
        end
        bit_q <= bit_q - 6'd1;
        if (bit_q == 6'd0) begin
          dist_q <= dist_q + (RootW+1)'(((SqW+1)'(cand_sq) <= sum_q) ? cand : root_q);
          side_q <= 1'b1;
          scl_q  <= 2'd0;
        end
      end
      ST_SCALE: begin
        // d*spl >> 16 computed as (d_lo*spl + (d_hi*spl << 32)) >> 16.
        if (scl_q == 2'd0) prod_q <= 68'(mul_p);
        else prod_q <= (prod_q + (68'(mul_p) << 32)) >> 16;
        scl_q <= scl_q + 2'd1;
      end
      ST_RD0: begin
        i0_q <= SW'(i0w);
        w_q  <= q[15:0];
        if (!in_range) frame_q <= frame_q + 1'b1;
      end
      ST_RD1: begin
        s0_q <= $signed(tr_rdata);
      end
      ST_ACC: begin
        acc_q   <= acc_sat;
        frame_q <= frame_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(out_q);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result moved while stalled");

  property p_busy;
    @(posedge clk_i) disable iff (!rst_ni) run_q |-> !s_axis_tready;
  endproperty
  a_busy: assert property (p_busy) else $error("ready while pixel in work");

  property p_frame_bound;
    @(posedge clk_i) disable iff (!rst_ni) run_q |-> frame_q < nf;
  endproperty
  a_frame_bound: assert property (p_frame_bound) else $error("frame beyond count");

endmodule

// ----- tb/sv/tfm_delay_and_sum_3d_core_test.sv -----
`timescale 1ns / 1ps

module tfm_delay_and_sum_3d_core_test;
  import tdas_pkg::*;

  // Predicts pixel sums from a mirror of the block's tables and checks results in order.
  class tdas_scoreboard;
    logic [8:0]  frame_cnt;
    logic [10:0] sample_cnt;
    logic [31:0] start_off;
    logic [31:0] samples_per_len;
    logic [31:0] elem_x [64];
    logic [31:0] elem_y [64];
    logic [31:0] elem_z [64];
    logic [5:0]  pair_tx [256];
    logic [5:0]  pair_rx [256];
    logic [15:0] trace [262144];
    bit          trace_written [262144];
    logic [47:0] pixel_q [$];
    int          errors;
    int          pixels_checked;
    int          loads_seen;

    function new();
      frame_cnt       = 9'd1;
      sample_cnt      = 11'd1024;
      start_off       = 32'd0;
      samples_per_len = 32'd65536;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_FRAME_COUNT:  frame_cnt = v[8:0];
        REG_SAMPLE_COUNT: sample_cnt = v[10:0];
        REG_START_OFFSET: start_off = v;
        default:          samples_per_len = v;
      endcase
    endfunction

    function logic [33:0] abs_diff(logic [31:0] a, logic [31:0] b);
      logic signed [33:0] d;
      d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
      return (d < 0) ? -d : d;
    endfunction

    // Floor of the Euclidean distance from a point to one element.
    function logic [34:0] elem_dist(logic [31:0] x, logic [31:0] y, logic [31:0] z, int e);
      logic [69:0] dx, dy, dz, sum, cand, root;
      dx = 70'(abs_diff(x, elem_x[e]));
      dy = 70'(abs_diff(y, elem_y[e]));
      dz = 70'(abs_diff(z, elem_z[e]));
      sum = dx * dx + dy * dy + dz * dz;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        cand = root | (70'd1 << b);
        if (cand * cand <= sum) root = cand;
      end
      return root[34:0];
    endfunction

    // Sum over frames of the interpolated trace sample; returns 0 when a
    // never-written trace entry would be read.
    function bit pixel_sum(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           output logic [47:0] value);
      int unsigned nf, ns, idx;
      logic [35:0] d;
      logic [71:0] prod;
      logic signed [72:0] q;
      longint i0, w, acc, lo, hi;
      bit safe;
      nf = (frame_cnt > 256) ? 256 : frame_cnt;
      ns = (sample_cnt > 1024) ? 1024 : sample_cnt;
      acc = 0;
      safe = 1;
      hi = (longint'(1) <<< 47) - 1;
      lo = -hi - 1;
      for (int f = 0; f < nf && ns >= 2; f++) begin
        d = 36'(elem_dist(x, y, z, pair_tx[f])) + 36'(elem_dist(x, y, z, pair_rx[f]));
        prod = 72'(d) * 72'(samples_per_len);
        q = $signed({1'b0, prod[71:16]}) - $signed(start_off);
        if (q < 0) continue;
        i0 = longint'(q[72:16]);
        if (i0 >= ns - 1) continue;
        w = longint'(q[15:0]);
        idx = 32'(f * 1024 + i0);
        if (!trace_written[idx] || !trace_written[idx + 1]) safe = 0;
        acc += (65536 - w) * longint'($signed(trace[idx]))
             + w * longint'($signed(trace[idx + 1]));
        if (acc > hi) acc = hi;
        if (acc < lo) acc = lo;
      end
      value = acc[47:0];
      return safe;
    endfunction

    // Applies one accepted word to the mirror and, for a pixel word, queues an expectation.
    function void note_word(logic [InDataW-1:0] w);
      func_e       fn;
      logic [47:0] v;
      fn = func_e'(w[1:0]);
      case (fn)
        FUNC_ELEM: begin
          elem_x[w[7:2]] = w[69:38];
          elem_y[w[7:2]] = w[101:70];
          elem_z[w[7:2]] = w[133:102];
        end
        FUNC_PAIR: begin
          pair_tx[w[15:8]] = w[31:26];
          pair_rx[w[15:8]] = w[37:32];
        end
        FUNC_TRACE: begin
          trace[{w[15:8], w[25:16]}] = w[149:134];
          trace_written[{w[15:8], w[25:16]}] = 1;
        end
        default: begin
          void'(pixel_sum(w[69:38], w[101:70], w[133:102], v));
          pixel_q.push_back(v);
        end
      endcase
      if (fn != FUNC_PIXEL) loads_seen++;
    endfunction

    function void check_pixel(logic [47:0] act);
      logic [47:0] exp_v;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel word, expected none, actual %h", $realtime, act);
        errors++;
        return;
      end
      exp_v = pixel_q.pop_front();
      pixels_checked++;
      if (act !== exp_v) begin
        $display("%0t: pixel_value mismatch, expected %h, actual %h", $realtime, exp_v, act);
        errors++;
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = REG_FRAME_COUNT;
  logic [CfgWidth-1:0] cfg_data_i = '0;

  tdas_scoreboard pix_sb = new();
  bit steady;
  int hold_asked;
  int hold_served;

  tfm_delay_and_sum_3d_core i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #40ms;
    $display("tfm_delay_and_sum_3d_core_test: FAIL");
    $finish;
  end

  // Result side: random stalls, long hold-offs on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (3000) @(negedge clk_i);
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) pix_sb.check_pixel(m_axis_tdata);
  end

  function automatic logic [InDataW-1:0] random_word(func_e fn);
    logic [InDataW-1:0] w;
    for (int i = 0; i < InDataW; i += 32) w[i +: 32] = $urandom();
    w[InDataW-1:150] = '0;
    w[1:0] = fn;
    return w;
  endfunction

  function automatic logic [31:0] near_coord();
    return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
  endfunction

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [InDataW-1:0] w);
    if (!steady && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    pix_sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pix_sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    pix_sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [8:0] fc, logic [10:0] sc, logic [31:0] off,
                           logic [31:0] spl);
    wait_results();
    write_reg(REG_FRAME_COUNT, 32'(fc));
    write_reg(REG_SAMPLE_COUNT, 32'(sc));
    write_reg(REG_START_OFFSET, off);
    write_reg(REG_SAMPLES_PER, spl);
  endtask

  task automatic write_elem(int e, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [InDataW-1:0] w;
    w = random_word(FUNC_ELEM);
    w[7:2] = 6'(e);
    w[69:38] = x;
    w[101:70] = y;
    w[133:102] = z;
    send_word(w);
  endtask

  task automatic write_trace(int f, int s);
    logic [InDataW-1:0] w;
    w = random_word(FUNC_TRACE);
    w[15:8] = 8'(f);
    w[25:16] = 10'(s);
    if ($urandom_range(0, 9) == 0) w[149:134] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    send_word(w);
  endtask

  // Sends one pixel whose reads all hit written trace entries; gives up
  // quietly if no such position turns up.
  task automatic send_pixel(bit far);
    logic [InDataW-1:0] w;
    logic [47:0] v;
    int k;
    for (int t = 0; t < 24; t++) begin
      w = random_word(FUNC_PIXEL);
      k = $urandom_range(0, 63);
      if (far) begin
        w[69:38] = edge_coord();
        w[101:70] = edge_coord();
        w[133:102] = edge_coord();
      end else begin
        w[69:38] = pix_sb.elem_x[k] + ($signed(near_coord()) >>> 1);
        w[101:70] = pix_sb.elem_y[k] + ($signed(near_coord()) >>> 1);
        w[133:102] = pix_sb.elem_z[k] + ($signed(near_coord()) >>> 1);
      end
      if (pix_sb.pixel_sum(w[69:38], w[101:70], w[133:102], v)) begin
        send_word(w);
        return;
      end
    end
  endtask

  task automatic random_phase(int n);
    logic [InDataW-1:0] w;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_pixel($urandom_range(0, 19) == 0);
      end else if (r < 65) begin
        if ($urandom_range(0, 9) == 0)
          write_elem($urandom_range(0, 63), edge_coord(), edge_coord(), edge_coord());
        else
          write_elem($urandom_range(0, 63), near_coord(), near_coord(), near_coord());
      end else if (r < 75) begin
        w = random_word(FUNC_PAIR);
        send_word(w);
      end else if (r < 95) begin
        write_trace($urandom_range(0, 7), $urandom_range(0, 39));
      end else begin
        write_trace($urandom_range(0, 255), $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    logic [InDataW-1:0] w;
    logic [10:0] sc;
    logic [31:0] off, spl;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Tables: every element, every frame pair, and a trace window.
    for (int e = 0; e < 64; e++) begin
      if (e == 63) write_elem(e, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      else if (e == 62) write_elem(e, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      else if (e == 61) write_elem(e, near_coord(), 32'h0, near_coord());
      else write_elem(e, near_coord(), near_coord(), near_coord());
    end
    for (int f = 0; f < 256; f++) begin
      w = random_word(FUNC_PAIR);
      w[15:8] = 8'(f);
      if (f == 0) w[37:26] = {6'd61, 6'd61};
      send_word(w);
    end
    for (int f = 0; f < 8; f++)
      for (int s = 0; s < 40; s++) write_trace(f, s);

    // Directed pixels under reset configuration, including far corners.
    repeat (4) send_pixel(0);
    repeat (3) send_pixel(1);

    // Zero frames, too-short traces, oversized counts, offset and scale extremes.
    configure(9'd0, 11'd1024, 32'd0, 32'd65536);
    send_pixel(0);
    configure(9'd4, 11'd0, 32'd0, 32'd65536);
    send_pixel(0);
    configure(9'd4, 11'd1, 32'd0, 32'd65536);
    send_pixel(0);
    configure(9'd8, 11'd2047, 32'd0, 32'd65536);
    repeat (2) send_pixel(0);
    configure(9'd8, 11'd1024, 32'h7FFF_FFFF, 32'd65536);
    send_pixel(0);
    configure(9'd8, 11'd1024, 32'h8000_0000, 32'd65536);
    send_pixel(0);
    configure(9'd8, 11'd1024, 32'd0, 32'hFFFF_FFFF);
    send_pixel(0);
    configure(9'd8, 11'd1024, 32'h0001_8000, 32'd0);
    send_pixel(0);

    // Every frame in play: two samples per trace for the remaining frames.
    for (int f = 8; f < 256; f++)
      for (int s = 0; s < 2; s++) write_trace(f, s);
    configure(9'd256, 11'd2, 32'd0, 32'($urandom_range(1, 2000)));
    repeat (2) send_pixel(0);
    configure(9'd511, 11'd2, 32'd0, 32'd0);
    send_pixel(0);

    // Random phases with fresh settings each time.
    for (int p = 0; p < 14; p++) begin
      case ($urandom_range(0, 5))
        0:       sc = 11'($urandom_range(0, 1));
        1:       sc = 11'd2047;
        2:       sc = 11'd1024;
        default: sc = 11'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       off = 32'h7FFF_FFFF;
        1:       off = 32'h8000_0000;
        default: off = 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      endcase
      case ($urandom_range(0, 5))
        0:       spl = 32'hFFFF_FFFF;
        1:       spl = 32'd0;
        2:       spl = 32'd65536;
        default: spl = $urandom_range(0, 200000);
      endcase
      configure(9'($urandom_range(1, 8)), sc, off, spl);
      steady = (p == 3);
      if (p == 5) hold_asked++;
      if (p == 8) begin
        random_phase(7);
        wait_results();
        random_phase(8);
      end else begin
        random_phase(15);
      end
      steady = 0;
    end

    wait_results();
    repeat (200) @(negedge clk_i);
    if (pix_sb.pending() != 0) begin
      $display("%0t: %0d pixel results never arrived", $realtime, pix_sb.pending());
      pix_sb.errors++;
    end
    $display("Covered %0d table loads and %0d checked pixels over many register settings,",
             pix_sb.loads_seen, pix_sb.pixels_checked);
    $display("with skipped frames, empty sums, random stalls and a long output hold-off.");
    if (pix_sb.errors == 0) begin
      $display("tfm_delay_and_sum_3d_core_test: PASS");
    end else begin
      $display("tfm_delay_and_sum_3d_core_test: FAIL");
    end
    $finish;
  end

endmodule
